### hw/rtl/fpfa_pkg.sv
// Shared constants and codes for the fixed partition fit allocator.
// No dependencies.
`default_nettype none

package fpfa_pkg;

  // Table geometry
  localparam int PARTITIONS = 32;
  localparam int SIZE_BITS  = 16;
  localparam int IDX_BITS   = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam int CNT_BITS   = $clog2(PARTITIONS + 1);
  localparam int COUNT_W    = 6;
  localparam int LIM_W      = (CNT_BITS > COUNT_W) ? CNT_BITS : COUNT_W;

  // Port payload widths
  localparam int ACTION_W   = 2;
  localparam int SLOT_W     = 5;
  localparam int BSIZE_W    = 16;
  localparam int S_TDATA_W  = 24;  // slot_index, block_size, pad
  localparam int S_TUSER_W  = 2;   // action
  localparam int M_TDATA_W  = 24;  // granted_index, granted_size, pad
  localparam int M_TUSER_W  = 1;   // granted
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;
  localparam int MODE_W     = 2;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_LOAD    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REQUEST = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd2;

  // Fit modes (code 3 acts as first fit)
  localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PART_COUNT = 1'd1;

endpackage

`default_nettype wire

### hw/rtl/fixed_partition_fit_allocator.sv
// Top level of the fixed partition fit allocator: request stream in, grant stream out.
// Depends on fpfa_pkg and fpfa_ram.
`default_nettype none

// Fixed partition fit allocator. Keeps a table of PARTITIONS partition sizes
// (in a RAM) and a used flag per partition (flip-flops, cleared by reset).
// Input requests: action 0 loads a partition size, 1 allocates, 2 clears all
// used flags. Load and clear give no response. An allocate
// request scans entries 0 .. min(partition_count, PARTITIONS)-1 through one
// RAM read port, one entry per cycle, with a single shared compare unit
// that checks fit and keeps the first, smallest or largest candidate
// (fit_mode 0/1/2; 3 acts as first fit; ties keep the lower index).
// With n = min(partition_count, PARTITIONS), an allocate holds s_tready low
// from when the request is taken until its response is loaded: the scan
// issues n RAM reads, checks the last registered read, closes the scan and
// then loads the response. A count of zero skips the last-read check.
// The response load waits while an earlier response is still held by
// m_tready low, which stretches the allocate by that stall.
// The response sits in an output register, so a new request is taken while
// it waits on m_tready.
// Sizes are never reset: allocate only over entries that were loaded.
// The user writes configuration (fit_mode, partition_count) only while idle;
// the block itself does not enforce it.
module fixed_partition_fit_allocator (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // request stream
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [fpfa_pkg::S_TDATA_W-1:0]    s_tdata,  // [4:0] slot_index, [20:5] block_size
  input  wire logic [fpfa_pkg::S_TUSER_W-1:0]    s_tuser,  // [1:0] action
  // response stream
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic      [fpfa_pkg::M_TDATA_W-1:0]    m_tdata,  // [4:0] granted_index, [20:5] granted_size
  output logic      [fpfa_pkg::M_TUSER_W-1:0]    m_tuser,  // [0] granted
  // configuration writes
  input  wire logic                              cfg_we,
  input  wire logic [fpfa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [fpfa_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import fpfa_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  localparam logic [LIM_W-1:0] PART_LIM = LIM_W'(PARTITIONS);

  logic [1:0]            state;
  logic [MODE_W-1:0]     fit_mode;
  logic [COUNT_W-1:0]    partition_count;
  logic [PARTITIONS-1:0] used;

  // scan registers
  logic [LIM_W-1:0]      addr;       // next entry to read
  logic [LIM_W-1:0]      limit;      // saturated entry count
  logic [SIZE_BITS-1:0]  need;
  logic                  pend;       // RAM data valid this cycle
  logic [IDX_BITS-1:0]   pend_idx;
  logic                  found;
  logic [IDX_BITS-1:0]   best_idx;
  logic [SIZE_BITS-1:0]  best_size;

  // output register
  logic                  out_valid;
  logic                  out_granted;
  logic [SLOT_W-1:0]     out_index;
  logic [BSIZE_W-1:0]    out_size;

  // decoded request
  logic [ACTION_W-1:0]   in_action;
  logic [SLOT_W-1:0]     in_slot;
  logic [SIZE_BITS-1:0]  in_size;
  logic                  in_accept;

  assign in_action = s_tuser[ACTION_W-1:0];
  assign in_slot   = s_tdata[SLOT_W-1:0];
  assign in_size   = s_tdata[SLOT_W +: SIZE_BITS];
  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;

  // saturate the configured count to the table depth
  logic [LIM_W-1:0] count_ext;
  logic [LIM_W-1:0] limit_sat;
  assign count_ext = LIM_W'(partition_count);
  assign limit_sat = (count_ext > PART_LIM) ? PART_LIM : count_ext;

  // size table
  logic                  ram_we;
  logic                  ram_re;
  logic [SIZE_BITS-1:0]  ram_rdata;
  logic                  slot_ok;

  assign slot_ok = ({{(LIM_W){1'b0}}, in_slot} < {{SLOT_W{1'b0}}, PART_LIM});
  assign ram_we  = in_accept && (in_action == ACT_LOAD) && slot_ok;
  assign ram_re  = (state == ST_SCAN) && (addr < limit);

  fpfa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (PARTITIONS)
  ) u_size_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_slot[IDX_BITS-1:0]),
    .wdata (in_size),
    .re    (ram_re),
    .raddr (addr[IDX_BITS-1:0]),
    .rdata (ram_rdata)
  );

  // shared compare unit: fit test plus one subtract for smaller/larger
  logic                 fits;
  logic [SIZE_BITS:0]   diff;
  logic                 is_less;
  logic                 is_more;
  logic                 take;

  assign fits    = !used[pend_idx] && (ram_rdata >= need);
  assign diff    = {1'b0, ram_rdata} - {1'b0, best_size};
  assign is_less = diff[SIZE_BITS];
  assign is_more = !diff[SIZE_BITS] && (diff != '0);

  always_comb begin
    take = 1'b0;
    if (pend && fits) begin
      if (!found) begin
        take = 1'b1;
      end else begin
        case (fit_mode)
          FIT_BEST:  take = is_less;
          FIT_WORST: take = is_more;
          default:   take = 1'b0;
        endcase
      end
    end
  end

  logic out_free;
  assign out_free = !out_valid || m_tready;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode        <= FIT_FIRST;
      partition_count <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIT_MODE:   fit_mode        <= cfg_data[MODE_W-1:0];
        REG_PART_COUNT: partition_count <= cfg_data[COUNT_W-1:0];
        default:        ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      used      <= '0;
      pend      <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // a new response replaces the one taken in the same cycle
      if ((state == ST_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      pend <= ram_re;
      if (take) begin
        found <= 1'b1;
      end

      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            case (in_action)
              ACT_CLEAR: used <= '0;
              ACT_REQUEST: begin
                found <= 1'b0;
                state <= ST_SCAN;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          // all reads issued and the last one evaluated
          if (!ram_re && !pend) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            if (found) begin
              used[best_idx] <= 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // scan datapath (no reset needed)
  always_ff @(posedge clk) begin
    if (in_accept) begin
      need  <= in_size;
      limit <= limit_sat;
      addr  <= '0;
    end else if (ram_re) begin
      addr <= addr + LIM_W'(1);
    end
    pend_idx <= addr[IDX_BITS-1:0];
    if (take) begin
      best_idx  <= pend_idx;
      best_size <= ram_rdata;
    end
    if ((state == ST_FIN) && out_free) begin
      out_granted <= found;
      out_index   <= found ? SLOT_W'(best_idx) : '0;
      out_size    <= found ? BSIZE_W'(best_size) : '0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_granted;
  assign m_tdata  = {{(M_TDATA_W - SLOT_W - BSIZE_W){1'b0}}, out_size, out_index};

endmodule

`default_nettype wire

### hw/rtl/fpfa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module fpfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic                                       re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
